// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre holds now, so post holds in the same cycle
`define ROP_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("rop assertion failed");

// pre matched, so post holds in the next cycle
`define ROP_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("rop assertion failed");

`endif

// ===== rtl/core/rop_pkg.sv =====
package rop_pkg;

   typedef enum logic [3:0] {
      OP_COPY    = 4'd0,
      OP_OR      = 4'd1,
      OP_AND     = 4'd2,
      OP_XOR     = 4'd3,
      OP_INVERT  = 4'd4,
      OP_INV_OR  = 4'd5,
      OP_INV_AND = 4'd6,
      OP_INV_XOR = 4'd7,
      OP_ADD     = 4'd8,
      OP_SUB     = 4'd9,
      OP_MUL     = 4'd10,
      OP_STIPPLE = 4'd11,
      OP_ALPHA   = 4'd12
   } op_type;

   localparam int ChanWidth = 8;
   localparam int NumChans  = 3;
   localparam logic [ChanWidth-1:0] ChanMax     = 8'd255;
   localparam logic [ChanWidth-1:0] AlphaOne    = 8'd128;
   localparam int                   AlphaShift  = 7;

   typedef struct packed {
      logic [3:0]         opcode;
      logic [31:0]        src_color;
      logic [31:0]        dest_pixel;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
   } req_type;

   typedef struct packed {
      logic [31:0] new_pixel;
      logic        write_enable;
   } rsp_type;

endpackage

// ===== rtl/core/raster_op_pixel_combiner_top.sv =====
// Raster-operation pixel combiner.
// Input channel (req_valid/req_ready/req_data): one beat per pixel, carrying
// the opcode, source colour, destination pixel read back and x/y position.
// Result channel (rsp_valid/rsp_ready/rsp_data): one beat per input beat, in
// order, with the pixel to write back and its write enable.
// Pipeline: an input register, one pass of combine logic (one 8x8 multiply
// per channel plus an add), then the result register.
// Throughput: 1 pixel per cycle while rsp_ready stays high; the per-channel multiplier sets the cycle.
// Stall: while rsp_ready is low the result holds; one more beat is still
// taken into the input register, after which req_ready drops until the
// result drains.
// Reset: synchronous, active high; both stages come up empty and req_ready
// is high in the first cycle after reset.
module raster_op_pixel_combiner_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rop_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rop_pkg::rsp_type rsp_data
);
   import rop_pkg::*;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff, s1_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   rsp_type alu_rsp;
   logic    s2_ready;

   rop_alu u_alu (
      .req (s1_data_ff),
      .rsp (alu_rsp)
   );

   assign s2_ready  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s2_ready;

   always_comb begin
      s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
      s1_data_in   = (req_valid && req_ready) ? req_data : s1_data_ff;
      rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;
      rsp_data_in  = (s2_ready && s1_valid_ff) ? alu_rsp : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/rop_alu.sv =====
module rop_alu (
   input  rop_pkg::req_type req,
   output rop_pkg::rsp_type rsp
);
   import rop_pkg::*;

   logic [31:0]                          inv_src;
   logic [ChanWidth-1:0]                 weight;
   logic [NumChans-1:0][ChanWidth-1:0]   src_ch;
   logic [NumChans-1:0][ChanWidth-1:0]   dst_ch;
   logic [NumChans-1:0][ChanWidth-1:0]   add_ch;
   logic [NumChans-1:0][ChanWidth-1:0]   sub_ch;
   logic [NumChans-1:0][ChanWidth-1:0]   mul_ch;
   logic [NumChans-1:0][ChanWidth-1:0]   blend_ch;
   logic [NumChans-1:0][ChanWidth-1:0]   mul_b;
   logic [NumChans-1:0][2*ChanWidth-1:0] prod;
   logic [NumChans-1:0][2*ChanWidth:0]   quo;
   logic [NumChans-1:0][ChanWidth:0]     sum;

   assign inv_src = ~req.src_color;
   assign weight  = AlphaOne - req.src_color[31:24];
   assign src_ch  = req.src_color[23:0];
   assign dst_ch  = req.dest_pixel[23:0];

   always_comb begin
      for (int i = 0; i < NumChans; i++) begin
         sum[i]    = {1'b0, dst_ch[i]} + {1'b0, src_ch[i]};
         add_ch[i] = sum[i][ChanWidth] ? ChanMax : sum[i][ChanWidth-1:0];
         sub_ch[i] = (dst_ch[i] > src_ch[i]) ? dst_ch[i] - src_ch[i] : '0;
         // one multiplier per channel, shared by mul and blend
         mul_b[i]  = (req.opcode == OP_ALPHA) ? weight : src_ch[i];
         prod[i]   = dst_ch[i] * mul_b[i];
         // floor(p / 255), exact over the 8x8 product range
         quo[i]    = {1'b0, prod[i]} + (2*ChanWidth+1)'(1)
                     + (2*ChanWidth+1)'(prod[i][2*ChanWidth-1:ChanWidth]);
         mul_ch[i] = quo[i][2*ChanWidth-1:ChanWidth];
         blend_ch[i] = src_ch[i] + prod[i][AlphaShift +: ChanWidth];
      end
   end

   always_comb begin
      rsp.new_pixel    = req.dest_pixel;
      rsp.write_enable = 1'b1;
      unique case (req.opcode)
         OP_COPY:    rsp.new_pixel = req.src_color;
         OP_OR:      rsp.new_pixel = req.dest_pixel | req.src_color;
         OP_AND:     rsp.new_pixel = req.dest_pixel & req.src_color;
         OP_XOR:     rsp.new_pixel = req.dest_pixel ^ req.src_color;
         OP_INVERT:  rsp.new_pixel = inv_src;
         OP_INV_OR:  rsp.new_pixel = req.dest_pixel | inv_src;
         OP_INV_AND: rsp.new_pixel = req.dest_pixel & inv_src;
         OP_INV_XOR: rsp.new_pixel = req.dest_pixel ^ inv_src;
         OP_ADD:     rsp.new_pixel = {8'h00, add_ch};
         OP_SUB:     rsp.new_pixel = {8'h00, sub_ch};
         OP_MUL:     rsp.new_pixel = {8'h00, mul_ch};
         OP_STIPPLE: begin
            // odd x+y writes the source, even leaves the pixel alone
            if (req.pos_x[0] ^ req.pos_y[0]) begin
               rsp.new_pixel = req.src_color;
            end else begin
               rsp.write_enable = 1'b0;
            end
         end
         OP_ALPHA:   rsp.new_pixel = {8'h00, blend_ch};
         default:    rsp.write_enable = 1'b0;
      endcase
   end

endmodule

// ===== rtl/core/rop_checker.sv =====
`include "assert_macros.svh"

module rop_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input rop_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rop_pkg::rsp_type rsp_data
);
   import rop_pkg::*;

   // a stalled result beat stays put
   `ROP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // with the result stage empty the input side is always open
   `ROP_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready)

   // an input beat reaches the output, via the input and result registers, when not back-pressured
   `ROP_ASSERT_NEXT(a_latency, req_valid && req_ready ##1 rsp_ready, rsp_valid)

   // copy passes the source straight through with a write
   `ROP_ASSERT_NEXT(a_copy_value, req_valid && req_ready && req_data.opcode == OP_COPY ##1 rsp_ready, rsp_data.new_pixel == $past(req_data.src_color, 2) && rsp_data.write_enable)

endmodule

bind raster_op_pixel_combiner_top rop_checker u_rop_checker (.*);

// ===== test/tb_raster_op_pixel_combiner_top.sv =====
`timescale 1ns / 1ps

module tb_raster_op_pixel_combiner_top;
   import rop_pkg::*;

   localparam int RandomBeats  = 1400;
   localparam int QuietLimit   = 2000;
   localparam int NoIdleFrom   = 500;
   localparam int NoIdleTo     = 800;
   localparam int IdlePercent  = 32;
   localparam int DrainSettle  = 8;
   localparam logic [3:0] OpReservedFirst = 4'(OP_ALPHA + 1);
   localparam logic [3:0] OpReservedLast  = 4'hF;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_beats[$];
   int      drain_before[$];
   rsp_type pixel_expect[$];
   int      outstanding   = 0;
   int      quiet_cycles  = 0;
   int      beats_issued  = 0;
   int      beats_checked = 0;
   int      mismatches    = 0;

   raster_op_pixel_combiner_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rsp_type combine_pixel(req_type beat);
      rsp_type     result;
      logic [31:0] src;
      logic [31:0] dst;
      logic [7:0]  d;
      logic [7:0]  s;
      logic [7:0]  w;
      logic [7:0]  chan_out;
      logic [8:0]  sum;
      logic [15:0] prod;
      src = beat.src_color;
      dst = beat.dest_pixel;
      result.new_pixel = dst;
      result.write_enable = 1'b1;
      // blend weight wraps for alpha above one
      w = AlphaOne - src[31:24];
      case (beat.opcode)
         OP_COPY:    result.new_pixel = src;
         OP_OR:      result.new_pixel = dst | src;
         OP_AND:     result.new_pixel = dst & src;
         OP_XOR:     result.new_pixel = dst ^ src;
         OP_INVERT:  result.new_pixel = ~src;
         OP_INV_OR:  result.new_pixel = dst | ~src;
         OP_INV_AND: result.new_pixel = dst & ~src;
         OP_INV_XOR: result.new_pixel = dst ^ ~src;
         OP_ADD, OP_SUB, OP_MUL, OP_ALPHA: begin
            result.new_pixel = '0;
            for (int c = 0; c < NumChans; c++) begin
               d = dst[c*ChanWidth +: ChanWidth];
               s = src[c*ChanWidth +: ChanWidth];
               sum = {1'b0, d} + s;
               prod = d * ((beat.opcode == OP_ALPHA) ? w : s);
               case (beat.opcode)
                  OP_ADD:  chan_out = sum[8] ? ChanMax : sum[7:0];
                  OP_SUB:  chan_out = (d > s) ? d - s : '0;
                  OP_MUL:  chan_out = 8'(prod / ChanMax);
                  default: chan_out = s + 8'(prod >> AlphaShift);
               endcase
               result.new_pixel[c*ChanWidth +: ChanWidth] = chan_out;
            end
         end
         OP_STIPPLE: begin
            // parity of x+y is the xor of the two low bits
            if (beat.pos_x[0] ^ beat.pos_y[0]) begin
               result.new_pixel = src;
            end else begin
               result.write_enable = 1'b0;
            end
         end
         default: result.write_enable = 1'b0;
      endcase
      return result;
   endfunction

   task automatic add_beat(input logic [3:0] op, input logic [31:0] src, dst,
                           input logic signed [15:0] x = 16'sd0, y = 16'sd0);
      req_type beat;
      beat.opcode     = op;
      beat.src_color  = src;
      beat.dest_pixel = dst;
      beat.pos_x      = x;
      beat.pos_y      = y;
      pending_beats.push_back(beat);
   endtask

   function automatic logic [31:0] pick_colour();
      logic [31:0] edge_colours[4] = '{32'h0, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h00FF_00FF};
      if ($urandom_range(4) == 0) begin
         return edge_colours[$urandom_range(3)];
      end
      return $urandom;
   endfunction

   // driver: one beat per handshake, holds payload until taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_beats.size() == 0) begin
            req_valid <= 1'b0;
         end else if (drain_before.size() != 0 && drain_before[0] == beats_issued) begin
            // hold off until every expected pixel has come back
            req_valid <= 1'b0;
            if (!req_valid && outstanding == 0) begin
               void'(drain_before.pop_front());
            end
         end else if ($urandom_range(99) < IdlePercent &&
                      (beats_issued < NoIdleFrom || beats_issued >= NoIdleTo)) begin
            req_valid <= 1'b0;
         end else begin
            req_data  <= pending_beats.pop_front();
            req_valid <= 1'b1;
            beats_issued++;
         end
      end
   end

   // monitor and result-side ready
   always @(posedge clock) begin
      rsp_type expected;
      if (reset) begin
         rsp_ready    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            pixel_expect.push_back(combine_pixel(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (pixel_expect.size() == 0) begin
               $error("result beat with no pixel expected: new_pixel %h write_enable %b",
                      rsp_data.new_pixel, rsp_data.write_enable);
               mismatches++;
            end else begin
               expected = pixel_expect.pop_front();
               if (rsp_data.new_pixel !== expected.new_pixel) begin
                  $error("new_pixel: expected %h, got %h",
                         expected.new_pixel, rsp_data.new_pixel);
                  mismatches++;
               end
               if (rsp_data.write_enable !== expected.write_enable) begin
                  $error("write_enable: expected %b, got %b",
                         expected.write_enable, rsp_data.write_enable);
                  mismatches++;
               end
            end
            beats_checked++;
         end
         outstanding  <= pixel_expect.size();
         quiet_cycles <= ((req_valid && req_ready) || (rsp_valid && rsp_ready)) ?
                         0 : quiet_cycles + 1;
         rsp_ready <= ($urandom_range(99) >= IdlePercent) ||
                      (beats_checked >= NoIdleFrom && beats_checked < NoIdleTo);
      end
   end

   initial begin
      req_type beat;

      // bitwise ops at the extremes
      add_beat(OP_COPY,    32'hFFFF_FFFF, 32'h0000_0000);
      add_beat(OP_COPY,    32'h0000_0000, 32'hFFFF_FFFF);
      add_beat(OP_OR,      32'hA5A5_A5A5, 32'h5A5A_0000);
      add_beat(OP_AND,     32'hFFFF_FFFF, 32'h1234_5678);
      add_beat(OP_XOR,     32'hFFFF_FFFF, 32'h0F0F_0F0F);
      add_beat(OP_INVERT,  32'h0000_0000, 32'hDEAD_BEEF);
      add_beat(OP_INVERT,  32'hFFFF_FFFF, 32'h0000_0000);
      add_beat(OP_INV_OR,  32'h00FF_00FF, 32'h0000_0000);
      add_beat(OP_INV_AND, 32'h0000_0000, 32'hFFFF_FFFF);
      add_beat(OP_INV_XOR, 32'h1234_5678, 32'hFFFF_FFFF);
      // saturating channels: clip, exact top, and upper byte dropped
      add_beat(OP_ADD,     32'h0001_7F01, 32'h00FF_80FF);
      add_beat(OP_ADD,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_beat(OP_SUB,     32'h0002_0202, 32'h0001_0203);
      add_beat(OP_SUB,     32'h0000_0000, 32'hFFFF_FFFF);
      add_beat(OP_MUL,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_beat(OP_MUL,     32'h00FF_80FF, 32'h00FF_8001);
      // stipple parity at zero and with coordinates at the ends of the range
      add_beat(OP_STIPPLE, 32'hCAFE_F00D, 32'h0BAD_0BAD, 16'sd0, 16'sd0);
      add_beat(OP_STIPPLE, 32'hCAFE_F00D, 32'h0BAD_0BAD, -16'sd32768, 16'sd32767);
      add_beat(OP_STIPPLE, 32'h1111_1111, 32'h2222_2222, 16'sd32767, 16'sd32767);
      // blend weights: full, zero, and the two wrapped cases
      add_beat(OP_ALPHA,   32'h0010_2030, 32'hFFFF_FFFF);
      add_beat(OP_ALPHA,   32'h8010_2030, 32'hFFFF_FFFF);
      add_beat(OP_ALPHA,   32'hFFF0_8040, 32'h00FF_80FF);
      add_beat(OP_ALPHA,   32'h81FF_FFFF, 32'hFFFF_FFFF);
      for (int op = int'(OpReservedFirst); op <= int'(OpReservedLast); op++) begin
         add_beat(4'(op), 32'hFFFF_FFFF, 32'h89AB_CDEF);
      end
      drain_before.push_back(pending_beats.size());
      drain_before.push_back(700);
      drain_before.push_back(1100);

      for (int i = 0; i < RandomBeats; i++) begin
         if ($urandom_range(9) == 0) begin
            beat.opcode = 4'($urandom_range(OpReservedLast, OpReservedFirst));
         end else begin
            beat.opcode = 4'($urandom_range(OP_ALPHA));
         end
         beat.src_color  = pick_colour();
         beat.dest_pixel = pick_colour();
         // mostly legal blend alphas, the rest anything
         if (beat.opcode == OP_ALPHA && $urandom_range(3) != 0) begin
            beat.src_color[31:24] = 8'($urandom_range(AlphaOne));
         end
         beat.pos_x = 16'($urandom);
         beat.pos_y = 16'($urandom);
         pending_beats.push_back(beat);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(negedge clock);
      end while ((pending_beats.size() != 0 || req_valid || outstanding != 0) &&
                 quiet_cycles < QuietLimit);

      if (quiet_cycles >= QuietLimit) begin
         $display("RESULT: ERROR");
      end else begin
         repeat (DrainSettle) @(negedge clock);
         if (mismatches == 0) begin
            $display("RESULT: OK");
         end else begin
            $display("RESULT: ERROR");
         end
      end
      $finish;
   end

endmodule
